FILE: hdl/ktt_pkg.sv
// Package for the keyframe timeline table: item types, codes and state encoding.
// Used by every module of the block except ktt_ram; depends on nothing.
package ktt_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int ENTRY_W = 168;   // key 32, size 32, offset 32, speed 64, cut 8

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_READX = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_UNCHANGED = 3'd3,
        ST_FULL      = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] key_frame;
        logic [15:0] width;
        logic [15:0] height;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic [63:0] speed_bits;
        logic [7:0]  cut_flag;
        logic [31:0] playhead;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_key_frame;
        logic [15:0] out_width;
        logic [15:0] out_height;
        logic signed [15:0] out_offset_x;
        logic signed [15:0] out_offset_y;
        logic [63:0] out_speed_bits;
        logic [7:0]  out_cut;
        logic [2:0]  status;
        logic [8:0]  entry_count;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_FWD_RD,
        S_FWD_CHK,
        S_BWD_CHK,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_OUT_RD,
        S_OUT_WAIT,
        S_DONE
    } t_state;

    // Controller -> datapath commands.
    typedef struct packed {
        logic       latch_in;
        logic       rd_cur;      // read entry at cursor
        logic       rd_next;     // read entry at cursor + 1
        logic       rd_prev;     // read entry at cursor - 1
        logic       rd_shift;    // read entry at shift pointer - 1
        logic       wr_shift;    // write read data to shift pointer
        logic       wr_new;      // write input entry at put address
        logic       put_at_cur;  // put address is cursor (else cursor + 1)
        logic       put_at_zero;
        logic       cur_inc;
        logic       cur_dec;
        logic       cur_zero;
        logic       cur_clamp;
        logic       shift_load;
        logic       shift_dec;
        logic       seek_play;   // seek target is playhead (else key)
        logic       set_count_one;
        logic       count_inc;
        logic       res_load;
        logic [2:0] res_status;
    } t_ctl;

    // Datapath -> controller status.
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic full;
        logic has_next;      // cursor + 1 < count
        logic at_zero;       // cursor == 0
        logic rd_le_target;  // read key <= seek target
        logic rd_gt_target;  // read key > seek target
        logic key_eq;        // entry key == input key
        logic view_diff;     // view fields differ
        logic shift_done;    // shift pointer reached put address
    } t_sts;

endpackage

FILE: hdl/ktt_ram.sv
// Generic single-port RAM with registered read.
// Standalone; no package needed.
module ktt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: hdl/ktt_datapath.sv
// Datapath of the keyframe table: entry memory, cursor, count, shift pointer, result.
// Depends on ktt_pkg and ktt_ram.
module ktt_datapath import ktt_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_ctl      i_ctl,
    output t_sts      o_sts,
    output t_out_item o_result
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_in_item      r_in;
    logic [AW-1:0] r_cur;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_shift;
    t_out_item     r_res;

    logic [AW-1:0]      addr;
    logic               we;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;
    logic [ENTRY_W-1:0] new_entry;
    logic [AW-1:0]      put_addr;
    logic [CW-1:0]      cur_ext;
    logic [31:0]        target;
    logic [31:0]        rd_key;

    assign new_entry = {r_in.key_frame, r_in.height, r_in.width, r_in.offset_y,
                        r_in.offset_x, r_in.speed_bits, r_in.cut_flag};
    assign rd_key    = rdata[ENTRY_W-1 -: 32];
    assign cur_ext   = CW'(r_cur);
    assign target    = i_ctl.seek_play ? r_in.playhead : r_in.key_frame;
    assign put_addr  = i_ctl.put_at_zero ? '0 : (i_ctl.put_at_cur ? r_cur : r_cur + 1'b1);

    always_comb begin
        we    = i_ctl.wr_shift | i_ctl.wr_new;
        wdata = i_ctl.wr_new ? new_entry : rdata;
        addr  = r_cur;
        priority if (i_ctl.wr_new)   addr = put_addr;
        else if (i_ctl.wr_shift)     addr = r_shift;
        else if (i_ctl.rd_next)      addr = r_cur + 1'b1;
        else if (i_ctl.rd_prev)      addr = r_cur - 1'b1;
        else if (i_ctl.rd_shift)     addr = r_shift - 1'b1;
    end

    ktt_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch_in) r_in <= i_item;
        if (i_ctl.res_load) begin
            r_res.out_key_frame  <= rdata[167:136];
            r_res.out_height     <= rdata[135:120];
            r_res.out_width      <= rdata[119:104];
            r_res.out_offset_y   <= rdata[103:88];
            r_res.out_offset_x   <= rdata[87:72];
            r_res.out_speed_bits <= rdata[71:8];
            r_res.out_cut        <= rdata[7:0];
            r_res.status         <= i_ctl.res_status;
            r_res.entry_count    <= 9'(r_count);
            // empty table shows zero fields
            if (r_count == '0) begin
                r_res.out_key_frame  <= '0;
                r_res.out_height     <= '0;
                r_res.out_width      <= '0;
                r_res.out_offset_y   <= '0;
                r_res.out_offset_x   <= '0;
                r_res.out_speed_bits <= '0;
                r_res.out_cut        <= '0;
            end
        end
        if (i_ctl.shift_load)     r_shift <= AW'(r_count);
        else if (i_ctl.shift_dec) r_shift <= r_shift - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_count <= '0;
        end else begin
            priority if (i_ctl.cur_zero) r_cur <= '0;
            else if (i_ctl.cur_clamp) begin
                if (cur_ext >= r_count) r_cur <= AW'(r_count - 1'b1);
            end
            else if (i_ctl.cur_inc)      r_cur <= r_cur + 1'b1;
            else if (i_ctl.cur_dec)      r_cur <= r_cur - 1'b1;
            if (i_ctl.set_count_one)     r_count <= CW'(1);
            else if (i_ctl.count_inc)    r_count <= r_count + 1'b1;
        end
    end

    always_comb begin
        o_sts.cmd          = t_cmd'(r_in.command);
        o_sts.empty        = (r_count == '0);
        o_sts.full         = (r_count >= CW'(CAPACITY));
        o_sts.has_next     = (cur_ext + 1'b1 < r_count);
        o_sts.at_zero      = (r_cur == '0);
        o_sts.rd_le_target = (rd_key <= target);
        o_sts.rd_gt_target = (rd_key > target);
        o_sts.key_eq       = (rd_key == r_in.key_frame);
        o_sts.view_diff    = (rdata[135:0] != new_entry[135:0]);
        o_sts.shift_done   = (r_shift == put_addr);
    end

    assign o_result = r_res;
endmodule

FILE: hdl/ktt_ctrl.sv
// Controller of the keyframe table: sequences seek, replace, insert shift and result.
// Depends on ktt_pkg.
module ktt_ctrl import ktt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    t_state  r_state, n_state;
    logic    r_phase, n_phase;     // 0: seek to key, 1: seek to playhead
    t_status r_status, n_status;
    logic    r_out_valid;

    logic take;
    assign take        = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_INIT;
            S_INIT: begin
                n_phase  = 1'b1;
                n_status = ST_OK;
                if (i_sts.cmd == CMD_INIT) n_state = S_PUT;
                else if (i_sts.empty) begin
                    n_status = ST_EMPTY;
                    n_state  = S_OUT_RD;
                end else begin
                    n_phase = (i_sts.cmd != CMD_WRITE);
                    n_state = S_FWD_RD;
                end
            end
            S_FWD_RD: n_state = i_sts.has_next ? S_FWD_CHK : S_BWD_CHK;
            S_FWD_CHK: n_state = i_sts.rd_le_target ? S_FWD_RD : S_BWD_CHK;
            S_BWD_CHK: begin
                if (i_sts.rd_gt_target && !i_sts.at_zero) n_state = S_BWD_CHK;
                else if (r_phase) n_state = S_OUT_RD;
                else n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.key_eq) begin
                    n_status = ST_REPLACED;
                    n_state  = S_PUT;
                end else if (i_sts.view_diff) begin
                    if (i_sts.full) begin
                        n_status = ST_FULL;
                        n_phase  = 1'b1;
                        n_state  = S_FWD_RD;
                    end else begin
                        n_status = ST_INSERTED;
                        n_state  = S_SHIFT_RD;
                    end
                end else begin
                    n_status = ST_UNCHANGED;
                    n_phase  = 1'b1;
                    n_state  = S_FWD_RD;
                end
            end
            S_SHIFT_RD: n_state = i_sts.shift_done ? S_PUT : S_SHIFT_WR;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_PUT: begin
                n_phase = 1'b1;
                n_state = (i_sts.cmd == CMD_INIT) ? S_OUT_RD : S_FWD_RD;
            end
            S_OUT_RD:   n_state = S_OUT_WAIT;
            S_OUT_WAIT: n_state = S_DONE;
            S_DONE:     if (!i_out_stall) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl            = '0;
        o_ctl.res_status = r_status;
        o_ctl.latch_in   = take;
        o_ctl.seek_play  = r_phase;
        unique case (r_state)
            S_IDLE: ;
            S_INIT: o_ctl.cur_clamp = (i_sts.cmd != CMD_INIT) && !i_sts.empty;
            S_FWD_RD: o_ctl.rd_next = i_sts.has_next;
            S_FWD_CHK: begin
                if (i_sts.rd_le_target) o_ctl.cur_inc = 1'b1;
                else o_ctl.rd_cur = 1'b1;   // fetch cursor entry for backward walk
            end
            S_BWD_CHK: begin
                // step back and fetch the entry below so it is ready next cycle
                if (i_sts.rd_gt_target && !i_sts.at_zero) begin
                    o_ctl.cur_dec = 1'b1;
                    o_ctl.rd_prev = 1'b1;
                end
                else if (!r_phase) o_ctl.rd_cur = 1'b1;
            end
            S_DECIDE: begin
                o_ctl.shift_load = 1'b1;
                o_ctl.rd_shift   = 1'b0;
            end
            S_SHIFT_RD: o_ctl.rd_shift = !i_sts.shift_done;
            S_SHIFT_WR: begin
                o_ctl.wr_shift  = 1'b1;
                o_ctl.shift_dec = 1'b1;
            end
            S_PUT: begin
                o_ctl.wr_new        = 1'b1;
                o_ctl.put_at_cur    = (r_status == ST_REPLACED);
                o_ctl.put_at_zero   = (i_sts.cmd == CMD_INIT);
                o_ctl.cur_zero      = (i_sts.cmd == CMD_INIT);
                o_ctl.set_count_one = (i_sts.cmd == CMD_INIT);
                o_ctl.count_inc     = (r_status == ST_INSERTED);
            end
            S_OUT_RD:   o_ctl.rd_cur = 1'b1;
            S_OUT_WAIT: o_ctl.res_load = 1'b1;
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_status    <= n_status;
            if (r_state == S_OUT_WAIT) r_out_valid <= 1'b1;
            else if (!i_out_stall)     r_out_valid <= 1'b0;
        end
    end
endmodule

FILE: hdl/keyframe_timeline_table.sv
// channel | direction | payload    | handshake
// in      | input     | t_in_item  | i_in_valid / o_in_stall
// out     | output    | t_out_item | o_out_valid / i_out_stall
//
// One item at a time: the item walks through seek steps forward and backward and, for
// an insert, moves entries one by one, all through the single port of the entry memory.
// Reset is synchronous, active low; it empties the table and zeroes the cursor.
// A stalled result holds; the next item is taken once the result leaves.
module keyframe_timeline_table import ktt_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);
    t_ctl ctl;
    t_sts sts;

    ktt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    ktt_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_result(o_out_item)
    );
endmodule

FILE: hdl/ktt_checker.sv
// Port-level checks for the keyframe timeline table, bound to the top level.
// Depends on ktt_pkg.
module ktt_checker import ktt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status <= ST_EMPTY)
        else $error("bad status");
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_EMPTY |-> o_out_item.entry_count == 9'd0)
        else $error("empty with entries");
endmodule

bind keyframe_timeline_table ktt_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);

FILE: bench/tb_top.sv
// Testbench for the keyframe timeline table: drives init, write and read items,
// predicts each result with a class-based table model, and checks every result.
// Depends on ktt_pkg and keyframe_timeline_table.
module tb_top;
    import ktt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = CAPACITY_DEF;
    localparam int LIMIT = 4000000;

    class keyframe_board;
        logic [31:0] keys [DEPTH];
        logic [31:0] sizes [DEPTH];
        logic [31:0] offs [DEPTH];
        logic [63:0] speeds [DEPTH];
        logic [7:0]  cuts [DEPTH];
        int unsigned used;
        int unsigned cur;
        t_out_item   pending [$];
        int          errors;
        int          checked;

        function new();
            used = 0;
            cur = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void seek(logic [31:0] f);
            if (used == 0) begin
                cur = 0;
                return;
            end
            if (cur >= used) cur = used - 1;
            while (cur + 1 < used && keys[cur + 1] <= f) cur++;
            while (cur > 0 && keys[cur] > f) cur--;
        endfunction

        function void put(int unsigned i, t_in_item it);
            keys[i] = it.key_frame;
            sizes[i] = {it.height, it.width};
            offs[i] = {it.offset_y, it.offset_x};
            speeds[i] = it.speed_bits;
            cuts[i] = it.cut_flag;
        endfunction

        function void note_item(t_in_item it);
            t_out_item r;
            t_status st;
            int unsigned at;
            st = ST_OK;
            r = '0;
            if (it.command == CMD_INIT) begin
                put(0, it);
                used = 1;
                cur = 0;
            end else if (used == 0) begin
                st = ST_EMPTY;
            end else if (it.command == CMD_WRITE) begin
                seek(it.key_frame);
                if (keys[cur] == it.key_frame) begin
                    put(cur, it);
                    st = ST_REPLACED;
                end else if (sizes[cur] != {it.height, it.width}
                        || offs[cur] != {it.offset_y, it.offset_x}
                        || speeds[cur] != it.speed_bits || cuts[cur] != it.cut_flag) begin
                    if (used >= DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        at = cur + 1;
                        for (int unsigned k = used; k > at; k--) begin
                            keys[k] = keys[k-1];
                            sizes[k] = sizes[k-1];
                            offs[k] = offs[k-1];
                            speeds[k] = speeds[k-1];
                            cuts[k] = cuts[k-1];
                        end
                        put(at, it);
                        used++;
                        st = ST_INSERTED;
                    end
                end else begin
                    st = ST_UNCHANGED;
                end
                seek(it.playhead);
            end else begin
                seek(it.playhead);
            end
            if (used > 0) begin
                r.out_key_frame = keys[cur];
                r.out_width = sizes[cur][15:0];
                r.out_height = sizes[cur][31:16];
                r.out_offset_x = offs[cur][15:0];
                r.out_offset_y = offs[cur][31:16];
                r.out_speed_bits = speeds[cur];
                r.out_cut = cuts[cur];
            end
            r.status = st;
            r.entry_count = used[8:0];
            pending.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item w;
            if (pending.size() == 0) begin
                report("unexpected result", 64'(got.entry_count), 64'd0);
                return;
            end
            w = pending.pop_front();
            checked++;
            if (got.out_key_frame !== w.out_key_frame)
                report("key_frame", 64'(got.out_key_frame), 64'(w.out_key_frame));
            if (got.out_width !== w.out_width)
                report("width", 64'(got.out_width), 64'(w.out_width));
            if (got.out_height !== w.out_height)
                report("height", 64'(got.out_height), 64'(w.out_height));
            if (got.out_offset_x !== w.out_offset_x)
                report("offset_x", 64'(unsigned'(got.out_offset_x)),
                       64'(unsigned'(w.out_offset_x)));
            if (got.out_offset_y !== w.out_offset_y)
                report("offset_y", 64'(unsigned'(got.out_offset_y)),
                       64'(unsigned'(w.out_offset_y)));
            if (got.out_speed_bits !== w.out_speed_bits)
                report("speed", got.out_speed_bits, w.out_speed_bits);
            if (got.out_cut !== w.out_cut) report("cut", 64'(got.out_cut), 64'(w.out_cut));
            if (got.status !== w.status) report("status", 64'(got.status), 64'(w.status));
            if (got.entry_count !== w.entry_count)
                report("entry_count", 64'(got.entry_count), 64'(w.entry_count));
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    keyframe_board board = new();
    int  cycles = 0;
    int  sent = 0;
    bit  long_hold = 1'b0;
    bit  fill_mode = 1'b0;
    logic [31:0] key_pool [8];
    t_in_item last_view;

    keyframe_timeline_table u_top (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) board.note_item(i_in_item);
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_item);
    end

    // Receiver stall pattern, with one long hold-off on request.
    initial begin
        int hold;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_stall <= 1'b1;
                for (hold = 0; hold < 3000; hold++) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (cycles % 2000 < 600) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    function automatic t_in_item rand_item(logic [1:0] cmd);
        t_in_item it;
        it.command = cmd;
        it.key_frame = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
        it.width = 16'($urandom);
        it.height = 16'($urandom);
        it.offset_x = 16'($urandom);
        it.offset_y = 16'($urandom);
        it.speed_bits = {$urandom, $urandom};
        it.cut_flag = 8'($urandom);
        it.playhead = ($urandom_range(0, 1) == 0) ? $urandom
                    : key_pool[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 4) == 0) begin
            // same view as last write so unchanged drops happen
            it.width = last_view.width;
            it.height = last_view.height;
            it.offset_x = last_view.offset_x;
            it.offset_y = last_view.offset_y;
            it.speed_bits = last_view.speed_bits;
            it.cut_flag = last_view.cut_flag;
        end
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        i_in_item <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
        if (it.command == CMD_WRITE) last_view = it;
    endtask

    task automatic go_idle(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic directed();
        t_in_item it;
        it = '0;
        it.command = CMD_READ;
        send_item(it);                     // read on empty table
        it.command = CMD_WRITE;
        send_item(it);                     // write on empty table
        it = '1;
        it.command = CMD_INIT;
        it.key_frame = 32'd100;
        send_item(it);
        it.command = CMD_WRITE;            // same view, higher key: unchanged
        it.key_frame = 32'd200;
        it.playhead = 32'hFFFF_FFFF;
        send_item(it);
        it.width = 16'h0;
        it.offset_x = 16'sh8000;
        it.speed_bits = 64'h0;
        send_item(it);                     // insert after 100
        it.cut_flag = 8'h00;
        send_item(it);                     // replace key 200
        it.key_frame = 32'd0;              // below entry 0: insert out of order
        it.height = 16'h0;
        it.offset_y = 16'sh7FFF;
        it.playhead = 32'd0;
        send_item(it);
        it.command = CMD_READX;
        it.playhead = 32'd150;
        send_item(it);
        it.command = CMD_READ;
        it.playhead = 32'd0;
        send_item(it);
        it.playhead = 32'hFFFF_FFFF;
        send_item(it);
        it = '0;
        it.command = CMD_INIT;
        send_item(it);
        drain();
    endtask

    initial begin
        int burst;
        for (int k = 0; k < 8; k++) key_pool[k] = $urandom_range(0, 40) * 10;
        key_pool[0] = 32'd0;
        key_pool[7] = 32'hFFFF_FFFF;
        last_view = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        directed();

        // fill to capacity, then push on the full table; the receiver holds off once at the start of the fill
        begin
            t_in_item it;
            it = rand_item(CMD_INIT);
            it.key_frame = 32'd0;
            send_item(it);
            long_hold = 1'b1;
            for (int k = 1; k < DEPTH + 6; k++) begin
                it = rand_item(CMD_WRITE);
                it.key_frame = 32'(k * 4);
                it.cut_flag = 8'(k);
                it.playhead = $urandom_range(0, 2) == 0 ? 32'd0 : $urandom;
                send_item(it);
            end
            for (int k = 0; k < 6; k++) begin
                it = rand_item(CMD_WRITE);
                it.key_frame = $urandom_range(0, DEPTH * 4 + 8);
                send_item(it);
            end
        end
        drain();

        while (sent < 500) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++) begin
                case ($urandom_range(0, 19))
                    0: send_item(rand_item(CMD_INIT));
                    1, 2, 3, 4, 5: send_item(rand_item($urandom_range(0, 1) ? CMD_READ
                                                                          : CMD_READX));
                    default: send_item(rand_item(CMD_WRITE));
                endcase
            end
            if ($urandom_range(0, 9) == 0) drain();
            else go_idle($urandom_range(0, 12));
        end
        drain();
        repeat (2 * DEPTH * 2 + 50) @(negedge i_clk);
        $display("sent %0d items, checked %0d results, including fill to capacity",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d errors, %0d results missing", board.errors, board.pending.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

FILE: files.f
hdl/ktt_pkg.sv
hdl/ktt_ram.sv
hdl/ktt_datapath.sv
hdl/ktt_ctrl.sv
hdl/keyframe_timeline_table.sv
hdl/ktt_checker.sv
bench/tb_top.sv
